// ===== rtl/rhn_pkg.sv =====
// rhn_pkg: shared constants, types and helpers for the running histogram normaliser
// used by rhn_div, running_histogram_normalizer_unit and the testbench; no dependencies
package rhn_pkg;

  localparam int NUM_BINS    = 32;
  localparam int COUNT_WIDTH = 32;

  // bits of a bin index
  localparam int BIN_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  // width of the sample range limit NUM_BINS * bin_width
  localparam int RANGE_W = 16 + BIN_W;
  // divisor width of the shared divider
  localparam int DIV_W   = (COUNT_WIDTH > RANGE_W) ? COUNT_WIDTH : RANGE_W;
  // quotient bits of one Q1.16 ratio (integer bit plus 16 fraction bits)
  localparam int QW      = 17;
  localparam int STEP_W  = $clog2(QW + 1);

  // input transfer actions
  localparam logic ACT_ACCUMULATE = 1'b0;
  localparam logic ACT_CLEAR      = 1'b1;

  // register indexes, one word apart
  typedef enum logic [1:0] {
    REG_LEFT_EDGE  = 2'd0,
    REG_BIN_WIDTH  = 2'd1,
    REG_DECIMATION = 2'd2
  } reg_idx_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // saturating increment of a counter
  function automatic count_t sat_inc(input count_t v);
    count_t res;
    res = (v == COUNT_MAX) ? v : v + count_t'(1);
    return res;
  endfunction

endpackage

// ===== rtl/rhn_ram.sv =====
// rhn_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rhn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rhn_div.sv =====
// rhn_div: shared restoring divider, one compare-and-subtract step per cycle
// depends on rhn_pkg
module rhn_div
  import rhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DIV_W:0]   num,
  input  logic [DIV_W-1:0] den,
  output div_sts_t         sts,
  output logic [QW-1:0]    quo
);

  logic [DIV_W:0]    rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [QW-1:0]     quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic              ge;
  logic [DIV_W:0]    rem_sub;

  // remainder stays below the divisor, so the doubled value still fits
  assign ge      = (rem_r >= {1'b0, den_r});
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[DIV_W-1:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding busy cycle");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !ctl.start |=> busy_r || done_r)
    else $error("divider stopped without signalling done");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !ctl.start |-> (rem_sub < {1'b0, den_r}) || (den_r == '0))
    else $error("divider remainder not reduced below divisor");

endmodule

// ===== rtl/running_histogram_normalizer_unit.sv =====
// running_histogram_normalizer_unit: top level of the running histogram normaliser
// depends on rhn_pkg, rhn_ram and rhn_div

// A running histogram of signed 16-bit samples with NUM_BINS bins of COUNT_WIDTH-bit
// saturating counters. An accumulate transfer (action 0) bins the sample by
// floor((sample - left_edge) / bin_width) and bumps that bin if the index is in range;
// the total counter counts every sample. After every decimation-th sample the block
// sends NUM_BINS result transfers, bin 0 first, each carrying bin count / total in
// unsigned Q1.16 (65536 is 1.0), with last on the final bin. A clear transfer
// (action 1) zeroes all counters and the decimation phase. Timing: one sample is held
// in the block while it works and in_stall is high meanwhile. A clear or an
// out-of-range sample is taken in the idle state without the divider; an in-range sample
// waits for the bit-per-cycle index division in the shared divider and the
// read-modify-write of the bin counter RAM. An emission also waits on any out_stall
// time: each bin is one RAM read and a 17-step Q1.16 division in the same shared
// divider, then a result transfer. Bin counters live in a RAM with one valid
// flip-flop per bin, so reset and clear take effect at once with no clearing pass.
module running_histogram_normalizer_unit
  import rhn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_bin_number,
  output logic [16:0] out_probability,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,  // ready for an input transfer
    S_IDX     = 7'b0000010,  // divider works out the bin index
    S_UPD     = 7'b0000100,  // write back the bumped bin count
    S_EM_RD   = 7'b0001000,  // read the bin count for emission
    S_EM_ST   = 7'b0010000,  // start the ratio division
    S_EM_WAIT = 7'b0100000,  // wait for the ratio
    S_OUT     = 7'b1000000   // hold the result until it is taken
  } state_t;

  // configuration registers
  logic [15:0] left_edge_r;
  logic [15:0] bin_width_r;
  logic [15:0] decimation_r;

  // histogram state
  count_t              total_r;
  logic [15:0]         phase_r;
  logic [NUM_BINS-1:0] bin_vld_r;

  // sequencer
  state_t     state_r;
  state_t     state_nxt;
  logic       hit_r;
  logic [BIN_W-1:0] idx_r;
  logic [BIN_W-1:0] bin_r;
  logic       rd_vld_r;

  // result register
  logic        out_valid_r;
  logic [5:0]  out_bin_number_r;
  logic [16:0] out_probability_r;
  logic        out_last_r;

  // datapath
  logic               in_acc;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic signed [16:0] diff;
  logic [RANGE_W-1:0] range_lim;
  logic               in_range;
  logic [15:0]        phase_inc;
  logic               phase_hit;
  logic               bin_is_last;

  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [DIV_W:0]   div_num;
  logic [DIV_W-1:0] div_den;
  logic [QW-1:0]    div_quo;

  logic             ram_we;
  logic [BIN_W-1:0] ram_raddr;
  count_t           ram_rdata;
  count_t           ram_wdata;

  // ---------------------------------------------------------------- configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_edge_r  <= 16'd0;
      bin_width_r  <= 16'd256;
      decimation_r <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEFT_EDGE:  left_edge_r  <= pwdata[15:0];
        REG_BIN_WIDTH:  bin_width_r  <= pwdata[15:0];
        REG_DECIMATION: decimation_r <= pwdata[15:0];
        default: ;  // unused address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LEFT_EDGE:  prdata = {16'd0, left_edge_r};
      REG_BIN_WIDTH:  prdata = {16'd0, bin_width_r};
      REG_DECIMATION: prdata = {16'd0, decimation_r};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- sample binning
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // 17-bit signed difference, never overflows
  assign diff = $signed({in_sample[15], in_sample}) - $signed({left_edge_r[15], left_edge_r});

  // in range when 0 <= diff < NUM_BINS * bin_width, so the quotient fits BIN_W bits
  assign range_lim = RANGE_W'(bin_width_r) * RANGE_W'(NUM_BINS);
  assign in_range  = !diff[16] && (bin_width_r != 16'd0) &&
                     (RANGE_W'(diff[15:0]) < range_lim);

  assign phase_inc   = phase_r + 16'd1;
  assign phase_hit   = (phase_inc == decimation_r);
  assign bin_is_last = (bin_r == BIN_W'(NUM_BINS - 1));

  // ---------------------------------------------------------------- shared divider
  // index: divisor bin_width scaled by 2^(BIN_W-1), BIN_W quotient bits
  // ratio: count over total, integer bit plus 16 fraction bits
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = '0;
    div_num       = '0;
    div_den       = '0;
    if (state_r == S_IDLE && in_acc && (in_action == ACT_ACCUMULATE) && in_range) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = STEP_W'(BIN_W);
      div_num       = (DIV_W + 1)'(diff[15:0]);
      div_den       = DIV_W'(bin_width_r) << (BIN_W - 1);
    end else if (state_r == S_EM_ST) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = STEP_W'(QW);
      div_num       = (DIV_W + 1)'(rd_vld_r ? ram_rdata : count_t'(0));
      div_den       = DIV_W'(total_r);
    end
  end

  rhn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------- bin counter RAM
  // the address follows the divider quotient while the index is produced
  assign ram_raddr = (state_r == S_IDX) ? div_quo[BIN_W-1:0] : bin_r;
  assign ram_we    = (state_r == S_UPD);
  // a bin not written since the last clear reads as zero
  assign ram_wdata = rd_vld_r ? sat_inc(ram_rdata) : count_t'(1);

  rhn_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == ACT_ACCUMULATE)) begin
          if (in_range) begin
            state_nxt = S_IDX;
          end else if (phase_hit) begin
            state_nxt = S_EM_RD;
          end
        end
      end
      S_IDX: begin
        if (div_sts.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD:     state_nxt = hit_r ? S_EM_RD : S_IDLE;
      S_EM_RD:   state_nxt = S_EM_ST;
      S_EM_ST:   state_nxt = S_EM_WAIT;
      S_EM_WAIT: begin
        if (div_sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = out_last_r ? S_IDLE : S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      phase_r     <= '0;
      bin_vld_r   <= '0;
      hit_r       <= 1'b0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_IDLE && in_acc) begin
        if (in_action == ACT_CLEAR) begin
          // clear: counters and phase back to zero
          total_r   <= '0;
          phase_r   <= '0;
          bin_vld_r <= '0;
        end else begin
          total_r <= sat_inc(total_r);
          phase_r <= phase_hit ? 16'd0 : phase_inc;
          hit_r   <= phase_hit;
          bin_r   <= '0;
        end
      end

      if (ram_we) begin
        bin_vld_r[idx_r] <= 1'b1;
      end

      if (state_r == S_EM_WAIT && div_sts.done) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_OUT && !out_stall) begin
        out_valid_r <= 1'b0;
        bin_r       <= bin_r + BIN_W'(1);
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    rd_vld_r <= bin_vld_r[ram_raddr];
    if (state_r == S_IDX && div_sts.done) begin
      idx_r <= div_quo[BIN_W-1:0];
    end
    if (state_r == S_EM_WAIT && div_sts.done) begin
      out_bin_number_r  <= 6'(bin_r);
      out_probability_r <= div_quo;
      out_last_r        <= bin_is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_number  = out_bin_number_r;
  assign out_probability = out_probability_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------- checks
  a_out_in_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result presented outside the hold state");

  a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_probability_r <= 17'd65536))
    else $error("probability above 1.0");

  a_last_on_final_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_bin_number_r == 6'(NUM_BINS - 1))))
    else $error("last flag not on the final bin");

  a_div_done_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_IDX || state_r == S_EM_WAIT))
    else $error("divider result arrived while nobody waits for it");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for running_histogram_normalizer_unit, driving samples and
// register writes, predicting every per-bin probability and checking each result transfer
// depends on rhn_pkg and the rtl top level running_histogram_normalizer_unit
module testbench
  import rhn_pkg::*;
();

  localparam int MAX_WAIT      = 13;
  // idle margin after the last result, covering any sample still in flight
  localparam int SETTLE_CYCLES = 16;
  // extra idle time after the last expected result, to catch stray transfers
  localparam int DRAIN_CYCLES  = 1000;

  // one expected per-bin result transfer
  typedef struct {
    logic [5:0]  bin_number;
    logic [16:0] probability;
    logic        last;
  } bin_share_t;

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_ACCUMULATE;
  logic [15:0] in_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_bin_number;
  logic [16:0] out_probability;
  logic        out_last;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  running_histogram_normalizer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bin_number  (out_bin_number),
    .out_probability (out_probability),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predicted histogram state, mirrors the block after every accepted transfer
  count_t            hist_bins [NUM_BINS] = '{default: '0};
  count_t            hist_total = '0;
  logic [15:0]       hist_phase = '0;
  // register copies, at their reset values
  logic signed [15:0] cur_left  = 16'sd0;
  logic [15:0]        cur_width = 16'd256;
  logic [15:0]        cur_decim = 16'd1;

  // per-bin probabilities still owed by the block, oldest first
  bin_share_t pending_shares [$];
  int         mismatches = 0;
  // when set neither side idles, giving back-to-back stretches
  bit         steady = 1'b0;

  function automatic count_t bump(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  // floor(num * 65536 / den), zero on an empty histogram
  function automatic logic [16:0] q16_share(input count_t num, input count_t den);
    logic [63:0] scaled;
    if (den == '0) return '0;
    scaled = 64'(num) << 16;
    return 17'(scaled / 64'(den));
  endfunction

  // apply one accepted transfer to the predicted histogram and queue any distribution
  function automatic void histogram_step(input logic action, input logic [15:0] sample);
    int         diff;
    int         w;
    int         slot;
    bin_share_t share;
    if (action == ACT_CLEAR) begin
      foreach (hist_bins[k]) hist_bins[k] = '0;
      hist_total = '0;
      hist_phase = '0;
      return;
    end
    // the total counts every sample, binned or not
    hist_total = bump(hist_total);
    diff = int'($signed(sample)) - int'(cur_left);
    w    = cur_width;
    // negative difference means left of bin 0, floor index is negative
    if (diff >= 0 && w != 0) begin
      slot = diff / w;
      if (slot < NUM_BINS) hist_bins[slot] = bump(hist_bins[slot]);
    end
    // phase wraps at 16 bits, so a lowered decimation is only met after the wrap
    hist_phase = hist_phase + 16'd1;
    if (hist_phase != cur_decim) return;
    hist_phase = '0;
    for (int k = 0; k < NUM_BINS; k++) begin
      share.bin_number  = 6'(k);
      share.probability = q16_share(hist_bins[k], hist_total);
      share.last        = (k == NUM_BINS - 1);
      pending_shares.push_back(share);
    end
  endfunction

  function automatic int pick_wait();
    return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // mostly samples that land in or just around the bins, the rest anywhere
  function automatic logic [15:0] pick_sample();
    int lo;
    int w;
    int v;
    int mode;
    lo   = int'(cur_left);
    w    = cur_width;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      v = lo + int'($urandom_range(0, NUM_BINS - 1)) * w + int'($urandom_range(0, w - 1));
    end else if (mode < 80) begin
      case ($urandom_range(0, 3))
        0:       v = lo - 1;
        1:       v = lo;
        2:       v = lo + NUM_BINS * w - 1;
        default: v = lo + NUM_BINS * w;
      endcase
    end else begin
      return 16'($urandom());
    end
    if (v < -32768 || v > 32767) return 16'($urandom());
    return 16'(v);
  endfunction

  // one input transfer: optional idle gap, then hold valid until the block takes it
  task automatic send_item(input logic action, input logic [15:0] sample);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= action;
    in_sample <= sample;
    do @(posedge clk); while (in_stall !== 1'b0);
    histogram_step(action, sample);
  endtask

  // let the block drain and go idle before touching its registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then the bus goes idle
  task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LEFT_EDGE:  cur_left  = value;
      REG_BIN_WIDTH:  cur_width = value;
      REG_DECIMATION: cur_decim = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: check each transfer against the oldest prediction, then maybe stall
  initial begin : result_checker
    bin_share_t want;
    int         hold;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_shares.size() == 0) begin
          $error("unexpected result: bin_number %0d probability %0d last %0d",
                 out_bin_number, out_probability, out_last);
          mismatches++;
        end else begin
          want = pending_shares.pop_front();
          check_field("bin_number", want.bin_number, out_bin_number);
          check_field("probability", want.probability, out_probability);
          check_field("last", want.last, out_last);
        end
        hold = pick_wait();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // reset values: left edge 0, width 256, every sample emits
  task automatic test_reset_defaults();
    send_item(ACT_ACCUMULATE, 16'd0);
    send_item(ACT_ACCUMULATE, 16'd255);
    send_item(ACT_ACCUMULATE, 16'd8191);   // top of the last bin
    send_item(ACT_ACCUMULATE, 16'd8192);   // just past the last bin, total only
    send_item(ACT_ACCUMULATE, 16'hFFFF);   // just left of bin 0
    send_item(ACT_ACCUMULATE, 16'h7FFF);
  endtask

  // clear right after an emission, back-to-back clears, a lone sample after clear
  task automatic test_clear();
    send_item(ACT_CLEAR, 16'($urandom()));
    send_item(ACT_ACCUMULATE, 16'd256);    // whole mass in bin 1
    send_item(ACT_CLEAR, 16'($urandom()));
    send_item(ACT_CLEAR, 16'($urandom()));
    send_item(ACT_ACCUMULATE, 16'hFFFF);   // nothing binned, every bin zero
  endtask

  // extreme left edges and bin widths
  task automatic test_range_edges();
    settle();
    write_register(REG_LEFT_EDGE, 16'h8000);
    write_register(REG_BIN_WIDTH, 16'd1);
    send_item(ACT_ACCUMULATE, 16'h8000);   // most negative sample, bin 0
    send_item(ACT_ACCUMULATE, 16'h801F);   // last bin
    send_item(ACT_ACCUMULATE, 16'h8020);   // one past the last bin
    settle();
    write_register(REG_LEFT_EDGE, 16'h7FFF);
    write_register(REG_BIN_WIDTH, 16'hFFFF);
    send_item(ACT_ACCUMULATE, 16'h7FFF);
    send_item(ACT_ACCUMULATE, 16'h7FFE);
    send_item(ACT_ACCUMULATE, 16'h8000);
    settle();
    write_register(REG_LEFT_EDGE, 16'h8000);
    send_item(ACT_ACCUMULATE, 16'h7FFF);   // full span over the widest bin lands in bin 1
  endtask

  // largest decimation, then decimation lowered below the running phase
  task automatic test_decimation();
    settle();
    write_register(REG_LEFT_EDGE, 16'd0);
    write_register(REG_BIN_WIDTH, 16'd256);
    write_register(REG_DECIMATION, 16'hFFFF);
    repeat (3) send_item(ACT_ACCUMULATE, pick_sample());
    settle();
    // phase now above decimation, so no distribution until a wrap or a clear
    write_register(REG_DECIMATION, 16'd2);
    repeat (3) send_item(ACT_ACCUMULATE, pick_sample());
    send_item(ACT_CLEAR, 16'($urandom()));
    repeat (2) send_item(ACT_ACCUMULATE, pick_sample());
  endtask

  // random register settings per stretch, mostly well-placed samples with some clears
  task automatic test_random_traffic();
    logic [15:0] left;
    logic [15:0] width;
    logic [15:0] decim;
    logic        action;
    for (int p = 0; p < 8; p++) begin
      settle();
      steady = (p % 3 == 2);
      case ($urandom_range(0, 3))
        0:       left = 16'h8000;
        1:       left = 16'h7FFF;
        default: left = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0:       width = 16'd1;
        1:       width = 16'hFFFF;
        2:       width = 16'($urandom_range(1, 64));
        default: width = 16'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 2))
        0:       decim = 16'd1;
        1:       decim = 16'($urandom_range(2, 4));
        default: decim = 16'($urandom_range(5, 16));
      endcase
      if (p == 0) decim = 16'd1;
      write_register(REG_LEFT_EDGE, left);
      write_register(REG_BIN_WIDTH, width);
      write_register(REG_DECIMATION, decim);
      if ($urandom_range(0, 1) == 1) send_item(ACT_CLEAR, 16'($urandom()));
      for (int i = 0; i < 24; i++) begin
        action = ($urandom_range(0, 99) < 4) ? ACT_CLEAR : ACT_ACCUMULATE;
        send_item(action, (action == ACT_CLEAR) ? 16'($urandom()) : pick_sample());
      end
    end
    steady = 1'b0;
  endtask

  initial begin : run
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_clear();
    test_range_edges();
    test_decimation();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("running_histogram_normalizer_unit test passed");
    end else begin
      $display("running_histogram_normalizer_unit test failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #20000000;
    $display("running_histogram_normalizer_unit test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rhn_pkg.sv
rtl/rhn_ram.sv
rtl/rhn_div.sv
rtl/running_histogram_normalizer_unit.sv
tb/testbench.sv
